FILE: hdl/euler_to_rotation_matrix_unit_macros.svh
// Assertion macros for the Euler-angle-to-rotation-matrix unit.
// Used by euler_to_rotation_matrix_unit; expects clk_i and rst_ni in scope.
`ifndef EULER_TO_ROTATION_MATRIX_UNIT_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_UNIT_MACROS_SVH

// same-cycle implication
`define E2R_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define E2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/e2r_pkg.sv
// Shared types, constants and elaboration-time functions for the
// Euler-angle-to-rotation-matrix unit. No dependencies.
`default_nettype none
package e2r_pkg;

  localparam int unsigned XFrac     = 48;          // CORDIC x/y fraction bits
  localparam int unsigned XW        = XFrac + 3;   // signed x/y width
  localparam int unsigned ZFrac     = 32;          // extra bits below one angle LSB
  localparam int unsigned ZW        = ZFrac + 16;  // signed residual angle width
  localparam int unsigned CordicStages = 44;
  localparam int unsigned Q28W      = 34;
  localparam int unsigned Q42W      = 52;
  localparam real         Pi        = 3.14159265358979323846;
  localparam real         AtanScale = (2.0 ** (ZFrac + 15)) / Pi;
  localparam logic signed [15:0] Q14One = 16'sd16384;

  typedef logic signed [15:0] q14_t;

  typedef enum logic [1:0] {
    ORD_ZYX = 2'd0,
    ORD_XYZ = 2'd1,
    ORD_ZXY = 2'd2
  } rot_order_e;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } cordic_t;

  typedef struct packed {
    q14_t sr;
    q14_t cr;
    q14_t sp;
    q14_t cp;
    q14_t sy;
    q14_t cy;
  } trig_t;

  // atan(2^-i) in residual angle units (pi = 2^(ZFrac+15))
  function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
    real r;
    r = $atan(2.0 ** (-1.0 * i)) * AtanScale;
    return ZW'(longint'(r));
  endfunction

  // CORDIC gain compensation for n iterations, Q(XFrac)
  function automatic logic signed [XW-1:0] cordic_gain(input int unsigned n);
    real k;
    k = 1.0;
    for (int unsigned i = 0; i < n; i++) begin
      k = k * ((1.0 + 2.0 ** (-2.0 * i)) ** (-0.5));
    end
    return XW'(longint'(k * (2.0 ** XFrac)));
  endfunction

endpackage
`default_nettype wire

FILE: hdl/euler_to_rotation_matrix_unit.sv
// Channel  Dir  Signals                          Payload
// in       in   in_valid_i / in_stall_o          e2r_pkg::in_item_t  (roll, pitch, yaw)
// out      out  out_valid_o / out_stall_i        e2r_pkg::out_item_t (m00..m22, Q2.14)
// cfg      in   cfg_we_i / cfg_wdata_i           rotation_order
// One transaction per cycle while no result sits stalled; the pipeline is the
// CORDIC cell chain plus sin/cos, two product and rounding registers.
// The whole pipeline advances together; it holds while a result sits stalled.
// Reset clears valid flags and rotation_order; no clearing pass.
// Depends on e2r_pkg, e2r_sincos, e2r_matrix and the macros header.
`default_nettype none
`include "euler_to_rotation_matrix_unit_macros.svh"
module euler_to_rotation_matrix_unit #(
  parameter int unsigned NumStages = e2r_pkg::CordicStages
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  e2r_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output e2r_pkg::out_item_t out_data_o
);

  localparam int unsigned Latency = NumStages + 4;

  logic [1:0]         order_q;
  logic [Latency-1:0] vld_d, vld_q;
  logic               en;
  e2r_pkg::trig_t     trig;

  assign en          = !(vld_q[Latency-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Latency-1];
  assign vld_d       = {vld_q[Latency-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= e2r_pkg::ORD_ZYX;
      vld_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= vld_d;
      end
    end
  end

  e2r_sincos #(.NumStages(NumStages)) u_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(in_data_i.roll_angle),
    .sin_o(trig.sr), .cos_o(trig.cr)
  );

  e2r_sincos #(.NumStages(NumStages)) u_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(in_data_i.pitch_angle),
    .sin_o(trig.sp), .cos_o(trig.cp)
  );

  e2r_sincos #(.NumStages(NumStages)) u_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(in_data_i.yaw_angle),
    .sin_o(trig.sy), .cos_o(trig.cy)
  );

  e2r_matrix u_matrix (
    .clk_i   (clk_i),
    .en_i    (en),
    .order_i (order_q),
    .trig_i  (trig),
    .mat_o   (out_data_o)
  );

  `E2R_ASSERT_NOW(a_identity_order, out_valid_o && order_q == 2'd3, out_data_o.m00 == e2r_pkg::Q14One && out_data_o.m01 == 16'sd0, "undefined order must give identity")
  `E2R_ASSERT_NOW(a_entry_range, out_valid_o, out_data_o.m22 <= e2r_pkg::Q14One && out_data_o.m22 >= -e2r_pkg::Q14One, "matrix entry out of range")
  `E2R_ASSERT_NEXT(a_hold_on_stall, out_valid_o && out_stall_i, vld_q == $past(vld_q), "pipeline moved while output stalled")

endmodule
`default_nettype wire

FILE: hdl/e2r_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation per clock while en_i is high.
// Depends on e2r_pkg.
`default_nettype none
module e2r_cordic_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  e2r_pkg::cordic_t  data_i,
  output e2r_pkg::cordic_t  data_o
);

  localparam logic signed [e2r_pkg::ZW-1:0] Atan = e2r_pkg::atan_step(Stage);

  e2r_pkg::cordic_t data_d, data_q;
  logic signed [e2r_pkg::XW-1:0] xs, ys;

  always_comb begin
    xs = data_i.x >>> Stage;
    ys = data_i.y >>> Stage;
    data_d.quad = data_i.quad;
    if (!data_i.z[e2r_pkg::ZW-1]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - Atan;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

FILE: hdl/e2r_sincos.sv
// Sine/cosine lane: quadrant split, chain of CORDIC cells, Q2.14 rounding.
// Depends on e2r_pkg and e2r_cordic_cell.
`default_nettype none
module e2r_sincos #(
  parameter int unsigned NumStages = e2r_pkg::CordicStages
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output e2r_pkg::q14_t      sin_o,
  output e2r_pkg::q14_t      cos_o
);

  localparam logic signed [e2r_pkg::XW-1:0] Gain = e2r_pkg::cordic_gain(NumStages);
  localparam logic signed [e2r_pkg::XW-1:0] Half =
    e2r_pkg::XW'(1) <<< (e2r_pkg::XFrac - 15);

  e2r_pkg::cordic_t chain [NumStages+1];
  e2r_pkg::q14_t bs, bc, sin_d, cos_d, sin_q, cos_q;

  function automatic e2r_pkg::q14_t to_q14(input logic signed [e2r_pkg::XW-1:0] v);
    logic signed [e2r_pkg::XW-1:0] s;
    s = (v + Half) >>> (e2r_pkg::XFrac - 14);
    if (s > e2r_pkg::XW'(e2r_pkg::Q14One)) begin
      return e2r_pkg::Q14One;
    end else if (s < -e2r_pkg::XW'(e2r_pkg::Q14One)) begin
      return -e2r_pkg::Q14One;
    end
    return s[15:0];
  endfunction

  assign chain[0].x    = Gain;
  assign chain[0].y    = '0;
  assign chain[0].z    = {2'b00, angle_i[13:0], {e2r_pkg::ZFrac{1'b0}}};
  assign chain[0].quad = angle_i[15:14];

  for (genvar i = 0; i < NumStages; i++) begin : g_cell
    e2r_cordic_cell #(.Stage(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .data_i (chain[i]),
      .data_o (chain[i+1])
    );
  end

  always_comb begin
    bc = to_q14(chain[NumStages].x);
    bs = to_q14(chain[NumStages].y);
    case (chain[NumStages].quad)
      2'd0: begin sin_d = bs;  cos_d = bc;  end
      2'd1: begin sin_d = bc;  cos_d = -bs; end
      2'd2: begin sin_d = -bs; cos_d = -bc; end
      default: begin sin_d = -bc; cos_d = bs; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

FILE: hdl/e2r_matrix.sv
// Rotation matrix composition: two exact 3x3 products and final rounding.
// Depends on e2r_pkg.
`default_nettype none
module e2r_matrix (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [1:0]         order_i,
  input  e2r_pkg::trig_t     trig_i,
  output e2r_pkg::out_item_t mat_o
);

  typedef e2r_pkg::q14_t mat3_t [3][3];
  typedef logic signed [e2r_pkg::Q28W-1:0] t_mat_t [3][3];
  typedef logic signed [e2r_pkg::Q42W-1:0] m_mat_t [3][3];

  localparam e2r_pkg::q14_t One  = e2r_pkg::Q14One;
  localparam e2r_pkg::q14_t Zero = '0;

  mat3_t rx, ry, rz, eye, a, b, c, c_q;
  t_mat_t t_d, t_q;
  m_mat_t m_d, m_q;
  e2r_pkg::q14_t r [3][3];
  e2r_pkg::out_item_t mat_d, mat_q;

  function automatic e2r_pkg::q14_t round_entry(input logic signed [e2r_pkg::Q42W-1:0] v);
    logic [e2r_pkg::Q42W-1:0] mag, q;
    mag = v[e2r_pkg::Q42W-1] ? e2r_pkg::Q42W'(-v) : e2r_pkg::Q42W'(v);
    q = (mag + (e2r_pkg::Q42W'(1) << 27)) >> 28;
    if (q > e2r_pkg::Q42W'(e2r_pkg::Q14One)) begin
      q = e2r_pkg::Q42W'(e2r_pkg::Q14One);
    end
    return v[e2r_pkg::Q42W-1] ? -q[15:0] : q[15:0];
  endfunction

  always_comb begin
    rx  = '{'{One, Zero, Zero}, '{Zero, trig_i.cr, -trig_i.sr}, '{Zero, trig_i.sr, trig_i.cr}};
    ry  = '{'{trig_i.cp, Zero, trig_i.sp}, '{Zero, One, Zero}, '{-trig_i.sp, Zero, trig_i.cp}};
    rz  = '{'{trig_i.cy, -trig_i.sy, Zero}, '{trig_i.sy, trig_i.cy, Zero}, '{Zero, Zero, One}};
    eye = '{'{One, Zero, Zero}, '{Zero, One, Zero}, '{Zero, Zero, One}};
    unique case (order_i)
      e2r_pkg::ORD_ZYX: begin a = rz; b = ry; c = rx; end
      e2r_pkg::ORD_XYZ: begin a = rx; b = ry; c = rz; end
      e2r_pkg::ORD_ZXY: begin a = rz; b = rx; c = ry; end
      default: begin a = eye; b = eye; c = eye; end
    endcase
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t_d[i][j] = e2r_pkg::Q28W'(a[i][0]) * e2r_pkg::Q28W'(b[0][j])
                  + e2r_pkg::Q28W'(a[i][1]) * e2r_pkg::Q28W'(b[1][j])
                  + e2r_pkg::Q28W'(a[i][2]) * e2r_pkg::Q28W'(b[2][j]);
        m_d[i][j] = e2r_pkg::Q42W'(t_q[i][0]) * e2r_pkg::Q42W'(c_q[0][j])
                  + e2r_pkg::Q42W'(t_q[i][1]) * e2r_pkg::Q42W'(c_q[1][j])
                  + e2r_pkg::Q42W'(t_q[i][2]) * e2r_pkg::Q42W'(c_q[2][j]);
        r[i][j]   = round_entry(m_q[i][j]);
      end
    end
    mat_d.m00 = r[0][0]; mat_d.m01 = r[0][1]; mat_d.m02 = r[0][2];
    mat_d.m10 = r[1][0]; mat_d.m11 = r[1][1]; mat_d.m12 = r[1][2];
    mat_d.m20 = r[2][0]; mat_d.m21 = r[2][1]; mat_d.m22 = r[2][2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= t_d;
      c_q   <= c;
      m_q   <= m_d;
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule
`default_nettype wire

FILE: bench/e2r_checker.sv
// Checker for euler_to_rotation_matrix_unit: predicts each rotation matrix and
// compares it field by field with the results that leave the block.
// Depends on e2r_pkg.
`default_nettype none
module e2r_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire e2r_pkg::in_item_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire e2r_pkg::out_item_t out_data_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      matrix_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint mat_t [3][3];

  localparam logic [63:0] Q62One  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PiQ62   = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] StepQ62 = (PiQ62 + 64'h4000) >> 15;
  localparam longint      Q14Unit = 16384;

  logic [1:0] order_q;
  e2r_pkg::out_item_t matrix_q [$];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[125:62];
  endfunction

  function automatic longint octant_q14(int unsigned t, bit want_sin);
    logic [63:0] x, x2, p, d;
    x  = 64'(t) * StepQ62;
    x2 = mul_q62(x, x);
    p  = Q62One;
    for (int n = 10; n >= 1; n--) begin
      d = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      p = Q62One - mul_q62(x2, p) / d;
    end
    if (want_sin) p = mul_q62(x, p);
    return longint'((p + (64'(1) << 47)) >> 48);
  endfunction

  task automatic sin_cos(logic [15:0] ang, output longint s, output longint c);
    logic [1:0]   quad;
    int unsigned  r;
    longint       bs, bc;
    quad = ang[15:14];
    r    = ang[13:0];
    if (r > 8192) begin
      bs = octant_q14(16384 - r, 1'b0);
      bc = octant_q14(16384 - r, 1'b1);
    end else begin
      bs = octant_q14(r, 1'b1);
      bc = octant_q14(r, 1'b0);
    end
    case (quad)
      2'd0: begin s = bs;  c = bc;  end
      2'd1: begin s = bc;  c = -bs; end
      2'd2: begin s = -bs; c = -bc; end
      default: begin s = -bc; c = bs; end
    endcase
  endtask

  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        r[i][j] = 0;
        for (int k = 0; k < 3; k++) r[i][j] += a[i][k] * b[k][j];
      end
    return r;
  endfunction

  function automatic logic [15:0] round_q14(longint v);
    logic [63:0] mag, q;
    mag = (v < 0) ? -v : v;
    q   = (mag + (64'(1) << 27)) >> 28;
    if (q > 64'(Q14Unit)) q = 64'(Q14Unit);
    return (v < 0) ? 16'(-q) : 16'(q);
  endfunction

  task automatic predict_matrix(e2r_pkg::in_item_t a, logic [1:0] ord,
                                output e2r_pkg::out_item_t res);
    longint sr, cr, sp, cp, sy, cy;
    mat_t   rx, ry, rz, m;
    logic [143:0] bits;
    sin_cos(a.roll_angle, sr, cr);
    sin_cos(a.pitch_angle, sp, cp);
    sin_cos(a.yaw_angle, sy, cy);
    rx = '{'{Q14Unit, 0, 0}, '{0, cr, -sr}, '{0, sr, cr}};
    ry = '{'{cp, 0, sp}, '{0, Q14Unit, 0}, '{-sp, 0, cp}};
    rz = '{'{cy, -sy, 0}, '{sy, cy, 0}, '{0, 0, Q14Unit}};
    case (ord)
      e2r_pkg::ORD_ZYX: m = mat_mul(mat_mul(rz, ry), rx);
      e2r_pkg::ORD_XYZ: m = mat_mul(mat_mul(rx, ry), rz);
      e2r_pkg::ORD_ZXY: m = mat_mul(mat_mul(rz, rx), ry);
      default: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? (Q14Unit << 28) : 0;
      end
    endcase
    for (int k = 0; k < 9; k++) bits[143 - 16 * k -: 16] = round_q14(m[k / 3][k % 3]);
    res = e2r_pkg::out_item_t'(bits);
  endtask

  string entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    e2r_pkg::out_item_t exp_m;
    logic [143:0] eb, gb;
    int errs;
    if (!rst_ni) begin
      order_q        <= e2r_pkg::ORD_ZYX;
      fail_count_o   <= 0;
      matrix_count_o <= 0;
      matrix_q.delete();
    end else begin
      if (cfg_we_i) order_q <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        predict_matrix(in_data_i, order_q, exp_m);
        matrix_q.push_back(exp_m);
      end
      if (out_valid_i && !out_stall_i) begin
        errs = 0;
        matrix_count_o <= matrix_count_o + 1;
        if (matrix_q.size() == 0) begin
          $error("unexpected matrix transaction %h", out_data_i);
          errs = 1;
        end else begin
          eb = matrix_q.pop_front();
          gb = out_data_i;
          for (int k = 0; k < 9; k++)
            if (eb[143 - 16 * k -: 16] !== gb[143 - 16 * k -: 16]) begin
              $error("%s expected %0d actual %0d", entry_name[k],
                     $signed(eb[143 - 16 * k -: 16]), $signed(gb[143 - 16 * k -: 16]));
              errs++;
            end
        end
        fail_count_o <= fail_count_o + errs;
      end
    end
  end

  assign pending_o = matrix_q.size();
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Top of the bench for euler_to_rotation_matrix_unit: clock, reset, angle
// stimulus, rotation-order writes and the verdict. Depends on e2r_pkg,
// e2r_checker and the unit itself.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OrderUnused = 2'd3;
  localparam int PhaseItems = 308;
  localparam int LatencyCycles = 60;
  localparam int CycleLimit = 200000;

  logic clk, rst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
  logic [1:0] cfg_wdata;
  e2r_pkg::in_item_t  in_data;
  e2r_pkg::out_item_t out_data;
  int fail_count, pending, matrix_count, cycles, sent;
  bit quiet, hold_req;

  euler_to_rotation_matrix_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  e2r_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .matrix_count_o(matrix_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 12);
      end
    end
  end

  task automatic send_angles(logic [15:0] r, logic [15:0] p, logic [15:0] y);
    if (!quiet)
      while ($urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(99) < 70) return 16'($urandom);
    return 16'($urandom_range(7) * 8192 + $urandom_range(2) - 1);
  endfunction

  task automatic set_order(logic [1:0] ord);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ord;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0] orders [5];
    orders = '{e2r_pkg::ORD_ZYX, e2r_pkg::ORD_XYZ, e2r_pkg::ORD_ZXY, OrderUnused,
               e2r_pkg::ORD_ZYX};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = e2r_pkg::ORD_ZYX;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_angles(16'h0000, 16'h0000, 16'h0000);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_angles(16'h8001, 16'h0001, 16'hFFFF);
    send_angles(16'h4000, 16'hC000, 16'h2000);
    send_angles(16'h1FFF, 16'h2001, 16'hE000);
    send_angles(16'h6000, 16'hA000, 16'h5FFF);
    send_angles(16'h3FFF, 16'h4001, 16'hBFFF);
    send_angles(16'h2000, 16'h2000, 16'h2000);
    send_angles(16'h0000, 16'h4000, 16'h0000);
    send_angles(16'h5555, 16'hAAAA, 16'h0F0F);
    send_angles(16'hF0F0, 16'h1234, 16'hEDCB);

    for (int ph = 0; ph < 5; ph++) begin
      set_order(orders[ph]);
      quiet = (ph == 1);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);

    $display("covered %0d angle triples and %0d matrices over orders ZYX, XYZ, ZXY, unused",
             sent, matrix_count);
    $display("including extreme angles, octant edges and a long output hold-off");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
